/* rtl/inverse_park_clarke_modulator_defines.svh */
// assertion macros shared by the modulator rtl
// no dependencies; included by files that carry concurrent checks
`ifndef INVERSE_PARK_CLARKE_MODULATOR_DEFINES_SVH
`define INVERSE_PARK_CLARKE_MODULATOR_DEFINES_SVH

// same-cycle implication, disabled in reset
`define ICM_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("icm check failed");

// next-cycle implication, disabled in reset
`define ICM_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("icm check failed");

`endif

/* rtl/icm_pkg.sv */
// package for the inverse park / clarke modulator
// holds defaults, sine polynomial constants, csr codes and shared types
package icm_pkg;

   localparam int ANGLE_BITS_DEF = 16;
   localparam int VOLT_BITS_DEF  = 16;
   localparam int CFG_BITS       = 15;

   // quarter-wave sine polynomial, q16
   localparam int unsigned SIN_A = 102944;
   localparam int unsigned SIN_B = 42048;
   localparam int unsigned SIN_C = 4640;

   // sqrt(3)/2 in q16
   localparam int unsigned HALF_SQRT3_Q16 = 56756;

   localparam logic       CENTERED_RST = 1'b1;
   localparam logic [CFG_BITS-1:0] SUPPLY_RST = 15'd3072;

   typedef enum logic [0:0] {
      CSR_CENTERED = 1'b0,
      CSR_SUPPLY   = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      QUAD_0 = 2'd0,
      QUAD_1 = 2'd1,
      QUAD_2 = 2'd2,
      QUAD_3 = 2'd3
   } quad_type;

   typedef struct packed {
      logic                centered;
      logic [CFG_BITS-1:0] supply;
   } cfg_type;

endpackage

/* rtl/icm_sincos.sv */
// four-stage sine/cosine unit: quarter-wave polynomial, forward and mirrored
// uses icm_pkg for polynomial constants and quadrant codes
module icm_sincos #(
   parameter int ANGLE_BITS = icm_pkg::ANGLE_BITS_DEF
) (
   input  logic                  clock,
   input  logic [3:0]            stage_en,
   input  logic [ANGLE_BITS-1:0] angle,
   output logic signed [15:0]    sin_o,
   output logic signed [15:0]    cos_o
);

   localparam int FRAC_BITS = ANGLE_BITS - 2;

   logic [FRAC_BITS-1:0] frac;
   logic [16:0]          x_fwd;
   logic [16:0]          x_in [2];
   logic [16:0]          x2_in [2];
   logic [33:0]          sq [2];

   // index 0 evaluates at x, index 1 at one minus x
   logic [16:0]          x1_ff [2];
   logic [16:0]          x2a_ff [2];
   icm_pkg::quad_type    quad1_ff;

   logic [31:0]          p2 [2];
   logic [15:0]          inner_in [2];
   logic [16:0]          x2b_ff [2];
   logic [16:0]          x2_ff2 [2];
   logic [15:0]          inner_ff [2];
   icm_pkg::quad_type    quad2_ff;

   logic [33:0]          p3 [2];
   logic [17:0]          t3 [2];
   logic [16:0]          mid_in [2];
   logic [16:0]          x3_ff [2];
   logic [16:0]          mid_ff [2];
   icm_pkg::quad_type    quad3_ff;

   logic [34:0]          p4 [2];
   logic [18:0]          s16 [2];
   logic [18:0]          s15w [2];
   logic signed [15:0]   s15 [2];
   logic signed [15:0]   sin_in;
   logic signed [15:0]   cos_in;
   logic signed [15:0]   sin_ff;
   logic signed [15:0]   cos_ff;

   assign frac = angle[FRAC_BITS-1:0];

   generate
      if (ANGLE_BITS <= 18) begin : g_frac_up
         assign x_fwd = 17'(frac) << (18 - ANGLE_BITS);
      end else begin : g_frac_down
         assign x_fwd = 17'(frac >> (ANGLE_BITS - 18));
      end
   endgenerate

   // stage 1: squares of both arguments
   always_comb begin
      x_in[0] = x_fwd;
      x_in[1] = 17'h10000 - x_fwd;
      for (int k = 0; k < 2; k++) begin
         sq[k]    = 34'(x_in[k]) * 34'(x_in[k]) + 34'd32768;
         x2_in[k] = sq[k][32:16];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         x1_ff    <= x_in;
         x2a_ff   <= x2_in;
         quad1_ff <= icm_pkg::quad_type'(angle[ANGLE_BITS-1 -: 2]);
      end
   end

   // stage 2: inner term b - c*x^2
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         p2[k]       = 32'(icm_pkg::SIN_C) * 32'(x2a_ff[k]) + 32'd32768;
         inner_in[k] = 16'(32'(icm_pkg::SIN_B) - 32'(p2[k][31:16]));
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         x2b_ff   <= x1_ff;
         x2_ff2   <= x2a_ff;
         inner_ff <= inner_in;
         quad2_ff <= quad1_ff;
      end
   end

   // stage 3: mid term a - x^2*inner
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         p3[k]     = 34'(x2_ff2[k]) * 34'(inner_ff[k]) + 34'd32768;
         t3[k]     = p3[k][33:16];
         mid_in[k] = 17'(18'(icm_pkg::SIN_A) - t3[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         x3_ff    <= x2b_ff;
         mid_ff   <= mid_in;
         quad3_ff <= quad2_ff;
      end
   end

   // stage 4: final product, q15 rounding, clamp, quadrant fold
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         p4[k]   = 35'(x3_ff[k]) * 35'(mid_ff[k]) + 35'd32768;
         s16[k]  = p4[k][34:16];
         s15w[k] = (s16[k] + 19'd1) >> 1;
         s15[k]  = (s15w[k] > 19'd32767) ? 16'sd32767 : signed'(s15w[k][15:0]);
      end
      case (quad3_ff)
         icm_pkg::QUAD_0: begin
            sin_in = s15[0];
            cos_in = s15[1];
         end
         icm_pkg::QUAD_1: begin
            sin_in = s15[1];
            cos_in = -s15[0];
         end
         icm_pkg::QUAD_2: begin
            sin_in = -s15[0];
            cos_in = -s15[1];
         end
         default: begin
            sin_in = -s15[1];
            cos_in = s15[0];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign sin_o = sin_ff;
   assign cos_o = cos_ff;

endmodule

/* rtl/icm_rotate.sv */
// two-stage inverse park rotation: four products, then alpha/beta sums
// uses icm_pkg for the default voltage width
module icm_rotate #(
   parameter int VOLT_BITS = icm_pkg::VOLT_BITS_DEF
) (
   input  logic                        clock,
   input  logic [1:0]                  stage_en,
   input  logic signed [15:0]          sin_i,
   input  logic signed [15:0]          cos_i,
   input  logic signed [VOLT_BITS-1:0] vq_i,
   input  logic signed [VOLT_BITS-1:0] vd_i,
   output logic signed [VOLT_BITS+16:0] alpha_o,
   output logic signed [VOLT_BITS+16:0] beta_o
);

   localparam int PROD_W = VOLT_BITS + 16;
   localparam int SUM_W  = VOLT_BITS + 17;

   logic signed [PROD_W-1:0] cd_ff, sq_ff, sd_ff, cq_ff;
   logic signed [SUM_W-1:0]  alpha_ff, beta_ff;

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         cd_ff <= PROD_W'(cos_i) * PROD_W'(vd_i);
         sq_ff <= PROD_W'(sin_i) * PROD_W'(vq_i);
         sd_ff <= PROD_W'(sin_i) * PROD_W'(vd_i);
         cq_ff <= PROD_W'(cos_i) * PROD_W'(vq_i);
      end
   end

   // 23 fraction bits in alpha and beta
   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         alpha_ff <= SUM_W'(cd_ff) - SUM_W'(sq_ff);
         beta_ff  <= SUM_W'(sd_ff) + SUM_W'(cq_ff);
      end
   end

   assign alpha_o = alpha_ff;
   assign beta_o  = beta_ff;

endmodule

/* rtl/icm_phase.sv */
// four-stage inverse clarke, centering or floor shift, rounding, saturation
// uses icm_pkg for the sqrt3/2 constant and the cfg_type struct
module icm_phase #(
   parameter int VOLT_BITS = icm_pkg::VOLT_BITS_DEF
) (
   input  logic                         clock,
   input  logic [3:0]                   stage_en,
   input  icm_pkg::cfg_type             cfg,
   input  logic signed [VOLT_BITS+16:0] alpha_i,
   input  logic signed [VOLT_BITS+16:0] beta_i,
   output logic signed [VOLT_BITS-1:0]  phase_a,
   output logic signed [VOLT_BITS-1:0]  phase_b,
   output logic signed [VOLT_BITS-1:0]  phase_c
);

   localparam int PW = VOLT_BITS + 36;
   localparam logic signed [PW-1:0] HSQ   = PW'(icm_pkg::HALF_SQRT3_Q16);
   localparam logic signed [PW-1:0] ROUND = PW'(64'd1 << 22);
   localparam logic signed [PW-1:0] HI    = {{(PW-VOLT_BITS+1){1'b0}}, {(VOLT_BITS-1){1'b1}}};
   localparam logic signed [PW-1:0] LO    = ~HI;

   logic signed [VOLT_BITS+16:0] alpha7_ff;
   logic signed [PW-1:0]         hb_ff;

   logic signed [PW-1:0] ale;
   logic signed [PW-1:0] p_in [3];
   logic signed [PW-1:0] p8_ff [3];

   logic signed [PW-1:0] pmin;
   logic signed [PW-1:0] off;
   logic signed [PW-1:0] madj_in;
   logic signed [PW-1:0] p9_ff [3];
   logic signed [PW-1:0] madj_ff;

   logic signed [PW-1:0]        w [3];
   logic signed [PW-1:0]        r [3];
   logic signed [VOLT_BITS-1:0] ph_in [3];
   logic signed [VOLT_BITS-1:0] ph_ff [3];

   // stage 7: sqrt3/2 * beta
   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         alpha7_ff <= alpha_i;
         hb_ff     <= PW'(beta_i) * HSQ;
      end
   end

   // stage 8: three phases with 39 fraction bits
   always_comb begin
      ale     = PW'(alpha7_ff);
      p_in[0] = ale <<< 16;
      p_in[1] = hb_ff - (ale <<< 15);
      p_in[2] = -hb_ff - (ale <<< 15);
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         p8_ff <= p_in;
      end
   end

   // stage 9: pick what to subtract, folded with the half-lsb rounding term
   always_comb begin
      pmin = p8_ff[0];
      if (p8_ff[1] < pmin) begin
         pmin = p8_ff[1];
      end
      if (p8_ff[2] < pmin) begin
         pmin = p8_ff[2];
      end
      off     = signed'(PW'({cfg.supply, 22'd0}));
      madj_in = (cfg.centered ? -off : pmin) - ROUND;
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         p9_ff   <= p8_ff;
         madj_ff <= madj_in;
      end
   end

   // stage 10: floor to q0.16 and saturate
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         w[k] = p9_ff[k] - madj_ff;
         r[k] = w[k] >>> 23;
         if (r[k] > HI) begin
            ph_in[k] = VOLT_BITS'(HI);
         end else if (r[k] < LO) begin
            ph_in[k] = VOLT_BITS'(LO);
         end else begin
            ph_in[k] = VOLT_BITS'(r[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         ph_ff <= ph_in;
      end
   end

   assign phase_a = ph_ff[0];
   assign phase_b = ph_ff[1];
   assign phase_c = ph_ff[2];

endmodule

/* rtl/inverse_park_clarke_modulator.sv */
// Inverse park / inverse clarke modulator. Takes one item per clock while
// req_tready is high (q and d voltage in signed Q8.8, electrical angle as a
// fraction of a turn) and returns three phase voltages, saturated to the
// signed VOLT_BITS range. The item passes ten register stages: four for the
// sine/cosine polynomial multiplier chain, two for the park rotation, four for
// the clarke step, offset and saturation. rsp_tvalid is the valid bit of the
// last stage, and the result leaves when rsp_tready is high. Each stage has
// its own valid bit and moves whenever the stage after it is empty or moving,
// so a stalled rsp side fills empty stages before req_tready drops. csr writes
// take effect at once and belong to quiet periods; index 0 is centered_mode,
// index 1 is supply_limit.
// Depends on icm_pkg, icm_sincos, icm_rotate, icm_phase and the defines header.
`include "inverse_park_clarke_modulator_defines.svh"

module inverse_park_clarke_modulator #(
   parameter int ANGLE_BITS = icm_pkg::ANGLE_BITS_DEF,
   parameter int VOLT_BITS  = icm_pkg::VOLT_BITS_DEF,
   localparam int REQ_W = ((2 * VOLT_BITS + ANGLE_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((3 * VOLT_BITS + 7) / 8) * 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // q_voltage, d_voltage, elec_angle, zero pad
   input  logic [REQ_W-1:0]               req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // phase_a, phase_b, phase_c, zero pad
   output logic [RSP_W-1:0]               rsp_tdata,
   input  logic                           csr_we,
   input  logic [0:0]                     csr_index,
   input  logic [icm_pkg::CFG_BITS-1:0]   csr_wdata
);

   localparam int NSTG = 10;

   logic [NSTG-1:0] valid_ff;
   logic [NSTG-1:0] valid_in;
   logic [NSTG-1:0] stage_en;

   icm_pkg::cfg_type cfg_ff;
   icm_pkg::cfg_type cfg_in;

   logic signed [VOLT_BITS-1:0] vq, vd;
   logic [ANGLE_BITS-1:0]       angle;
   logic signed [VOLT_BITS-1:0] vq_ff [4];
   logic signed [VOLT_BITS-1:0] vd_ff [4];

   logic signed [15:0]           sin_w, cos_w;
   logic signed [VOLT_BITS+16:0] alpha_w, beta_w;
   logic signed [VOLT_BITS-1:0]  phase_a, phase_b, phase_c;

   assign vq    = signed'(req_tdata[VOLT_BITS-1:0]);
   assign vd    = signed'(req_tdata[2*VOLT_BITS-1:VOLT_BITS]);
   assign angle = req_tdata[2*VOLT_BITS+ANGLE_BITS-1:2*VOLT_BITS];

   // a stage moves when it is empty or its successor moves
   always_comb begin
      stage_en[NSTG-1] = !valid_ff[NSTG-1] || rsp_tready;
      for (int i = NSTG - 2; i >= 0; i--) begin
         stage_en[i] = !valid_ff[i] || stage_en[i+1];
      end
      valid_in[0] = stage_en[0] ? req_tvalid : valid_ff[0];
      for (int i = 1; i < NSTG; i++) begin
         valid_in[i] = stage_en[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = stage_en[0];
   assign rsp_tvalid = valid_ff[NSTG-1];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (icm_pkg::csr_index_type'(csr_index))
            icm_pkg::CSR_CENTERED: cfg_in.centered = csr_wdata[0];
            icm_pkg::CSR_SUPPLY:   cfg_in.supply   = csr_wdata;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.centered <= icm_pkg::CENTERED_RST;
         cfg_ff.supply   <= icm_pkg::SUPPLY_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // voltages ride alongside the sine/cosine stages
   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         vq_ff[0] <= vq;
         vd_ff[0] <= vd;
      end
      for (int i = 1; i < 4; i++) begin
         if (stage_en[i]) begin
            vq_ff[i] <= vq_ff[i-1];
            vd_ff[i] <= vd_ff[i-1];
         end
      end
   end

   icm_sincos #(
      .ANGLE_BITS(ANGLE_BITS)
   ) u_sincos (
      .clock    (clock),
      .stage_en (stage_en[3:0]),
      .angle    (angle),
      .sin_o    (sin_w),
      .cos_o    (cos_w)
   );

   icm_rotate #(
      .VOLT_BITS(VOLT_BITS)
   ) u_rotate (
      .clock    (clock),
      .stage_en (stage_en[5:4]),
      .sin_i    (sin_w),
      .cos_i    (cos_w),
      .vq_i     (vq_ff[3]),
      .vd_i     (vd_ff[3]),
      .alpha_o  (alpha_w),
      .beta_o   (beta_w)
   );

   icm_phase #(
      .VOLT_BITS(VOLT_BITS)
   ) u_phase (
      .clock    (clock),
      .stage_en (stage_en[9:6]),
      .cfg      (cfg_ff),
      .alpha_i  (alpha_w),
      .beta_i   (beta_w),
      .phase_a  (phase_a),
      .phase_b  (phase_b),
      .phase_c  (phase_c)
   );

   assign rsp_tdata = RSP_W'({phase_c, phase_b, phase_a});

   `ICM_ASSERT_NXT(a_accept_enters, clock, reset, req_tvalid && req_tready, valid_ff[0])
   `ICM_ASSERT_IMP(a_full_backpressure, clock, reset, (&valid_ff) && !rsp_tready, !req_tready)
   `ICM_ASSERT_IMP(a_empty_out_ready, clock, reset, !rsp_tvalid, req_tready)
   `ICM_ASSERT_NXT(a_mid_stage_holds, clock, reset, valid_ff[4] && !stage_en[4], valid_ff[4])

endmodule

/* tb/tb_inverse_park_clarke_modulator.sv */
// testbench for inverse_park_clarke_modulator: directed and random voltage commands,
// self-checked against a fixed-point predictor of sine/cosine, park and clarke steps
// depends on icm_pkg and the modulator rtl
module tb_inverse_park_clarke_modulator;

   localparam int REQ_W = 48;
   localparam int RSP_W = 48;

   typedef struct packed {
      logic signed [15:0] phase_c;
      logic signed [15:0] phase_b;
      logic signed [15:0] phase_a;
   } phase_set_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   // q_voltage, d_voltage, elec_angle
   logic [REQ_W-1:0]             req_tdata = '0;
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   // phase_a, phase_b, phase_c
   logic [RSP_W-1:0]             rsp_tdata;
   logic                         csr_we = 1'b0;
   logic [0:0]                   csr_index = '0;
   logic [icm_pkg::CFG_BITS-1:0] csr_wdata = '0;

   // our copy of the control registers
   logic                         cfg_centered = icm_pkg::CENTERED_RST;
   logic [icm_pkg::CFG_BITS-1:0] cfg_supply = icm_pkg::SUPPLY_RST;

   phase_set_type pending_phases[$];
   int            mismatch_count = 0;
   int unsigned   commands_sent = 0;
   int unsigned   phase_sets_seen = 0;
   int unsigned   input_stalls = 0;
   int unsigned   send_idle_pct = 0;
   int unsigned   recv_stall_pct = 0;
   int unsigned   hold_request = 0;
   int unsigned   hold_served = 0;
   int unsigned   hold_left = 0;
   int unsigned   hold_len = 80;

   inverse_park_clarke_modulator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // quarter-wave sine, x in q16 (0..65536), result in q1.15
   function automatic longint quarter_wave_sine(longint unsigned x);
      longint unsigned sq, inner, mid, s16, s15;
      sq    = (x * x + 64'd32768) >> 16;
      inner = 64'(icm_pkg::SIN_B) - ((64'(icm_pkg::SIN_C) * sq + 64'd32768) >> 16);
      mid   = 64'(icm_pkg::SIN_A) - ((sq * inner + 64'd32768) >> 16);
      s16   = (x * mid + 64'd32768) >> 16;
      s15   = (s16 + 64'd1) >> 1;
      if (s15 > 64'd32767) begin
         s15 = 64'd32767;
      end
      return longint'(s15);
   endfunction

   // 39 fraction bits down to q0.16, round half up, saturate
   function automatic logic signed [15:0] round_phase(longint w);
      longint r;
      r = (w + (longint'(1) <<< 22)) >>> 23;
      if (r > 32767) begin
         r = 32767;
      end else if (r < -32768) begin
         r = -32768;
      end
      return r[15:0];
   endfunction

   function automatic phase_set_type phase_voltages(logic signed [15:0] vq,
                                                    logic signed [15:0] vd,
                                                    logic [15:0] ang);
      icm_pkg::quad_type quad;
      longint unsigned   x;
      longint            s_fwd, s_rev, sn, cs, al, be, pa, pb, pc, m, off;
      phase_set_type     p;
      quad  = icm_pkg::quad_type'(ang[15:14]);
      x     = 64'({ang[13:0], 2'b00});
      s_fwd = quarter_wave_sine(x);
      s_rev = quarter_wave_sine(64'd65536 - x);
      case (quad)
         icm_pkg::QUAD_0: begin
            sn = s_fwd;
            cs = s_rev;
         end
         icm_pkg::QUAD_1: begin
            sn = s_rev;
            cs = -s_fwd;
         end
         icm_pkg::QUAD_2: begin
            sn = -s_fwd;
            cs = -s_rev;
         end
         default: begin
            sn = -s_rev;
            cs = s_fwd;
         end
      endcase
      al = cs * longint'(vd) - sn * longint'(vq);
      be = sn * longint'(vd) + cs * longint'(vq);
      pa = al * 65536;
      pb = -al * 32768 + longint'(icm_pkg::HALF_SQRT3_Q16) * be;
      pc = -al * 32768 - longint'(icm_pkg::HALF_SQRT3_Q16) * be;
      if (cfg_centered) begin
         // half of supply, exact even when supply is odd
         off = longint'(cfg_supply) <<< 22;
         pa += off;
         pb += off;
         pc += off;
      end else begin
         m = pa;
         if (pb < m) begin
            m = pb;
         end
         if (pc < m) begin
            m = pc;
         end
         pa -= m;
         pb -= m;
         pc -= m;
      end
      p.phase_a = round_phase(pa);
      p.phase_b = round_phase(pb);
      p.phase_c = round_phase(pc);
      return p;
   endfunction

   task automatic check_phase_set(logic [RSP_W-1:0] data);
      phase_set_type got, want;
      got = data;
      phase_sets_seen++;
      if (pending_phases.size() == 0) begin
         $error("phase set with no command pending: %h", data);
         mismatch_count++;
      end else begin
         want = pending_phases.pop_front();
         if (got.phase_a !== want.phase_a) begin
            $error("phase_a: expected %0d, actual %0d", want.phase_a, got.phase_a);
            mismatch_count++;
         end
         if (got.phase_b !== want.phase_b) begin
            $error("phase_b: expected %0d, actual %0d", want.phase_b, got.phase_b);
            mismatch_count++;
         end
         if (got.phase_c !== want.phase_c) begin
            $error("phase_c: expected %0d, actual %0d", want.phase_c, got.phase_c);
            mismatch_count++;
         end
      end
   endtask

   // result side: check accepted items, then pick next ready, with long holds on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_phase_set(rsp_tdata);
         end
         if (req_tvalid && !req_tready) begin
            input_stalls++;
         end
         if (hold_served != hold_request) begin
            hold_served <= hold_request;
            hold_left   <= hold_len;
            rsp_tready  <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   task automatic send_command(logic signed [15:0] vq, logic signed [15:0] vd, logic [15:0] ang);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {ang, vd, vq};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      pending_phases.push_back(phase_voltages(vq, vd, ang));
      commands_sent++;
   endtask

   task automatic write_csr(icm_pkg::csr_index_type idx, logic [icm_pkg::CFG_BITS-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == icm_pkg::CSR_CENTERED) begin
         cfg_centered = value[0];
      end else begin
         cfg_supply = value;
      end
   endtask

   task automatic wait_for_results();
      int unsigned waited;
      waited = 0;
      req_tvalid <= 1'b0;
      while (pending_phases.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      if (pending_phases.size() != 0) begin
         $error("%0d phase sets never arrived", pending_phases.size());
         mismatch_count++;
      end
      repeat (14) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_voltage();
      case ($urandom_range(9)) inside
         0: return 16'h7fff;
         1: return 16'h8000;
         [2:4]: return 16'(int'($urandom_range(4096)) - 2048);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_angle();
      if ($urandom_range(7) == 0) begin
         // near a quadrant boundary
         return 16'({$urandom_range(3), 14'd0} + int'($urandom_range(2)) - 1);
      end
      return 16'($urandom);
   endfunction

   task automatic run_random(int unsigned count);
      for (int unsigned i = 0; i < count; i++) begin
         send_command(pick_voltage(), pick_voltage(), pick_angle());
      end
   endtask

   // reset register values, voltage and angle extremes, saturation both ways
   task automatic test_centered_extremes();
      send_command(16'sd0, 16'sd0, 16'd0);
      send_command(16'sd32767, 16'sd0, 16'd0);
      send_command(16'sd32767, 16'sd0, 16'd16384);
      send_command(16'sd32767, 16'sd0, 16'd32768);
      send_command(16'sd32767, 16'sd0, 16'd49152);
      send_command(-16'sd32768, -16'sd32768, 16'd65535);
      send_command(16'sd0, 16'sd32767, 16'd16383);
      send_command(16'sd2560, -16'sd1280, 16'd8192);
      send_command(-16'sd1, 16'sd1, 16'd43690);
      wait_for_results();
   endtask

   // minimum phase pinned at zero, only the top can saturate
   task automatic test_shifted_minimum();
      write_csr(icm_pkg::CSR_CENTERED, 15'd0);
      send_command(16'sd0, 16'sd0, 16'd12345);
      send_command(16'sd32767, 16'sd32767, 16'd0);
      send_command(-16'sd32768, 16'sd0, 16'd21845);
      send_command(16'sd768, -16'sd512, 16'd60000);
      send_command(16'sd3000, 16'sd0, 16'd32767);
      wait_for_results();
   endtask

   // supply at zero, odd (half lsb offset) and at its top
   task automatic test_supply_limits();
      write_csr(icm_pkg::CSR_CENTERED, 15'd1);
      write_csr(icm_pkg::CSR_SUPPLY, 15'd0);
      send_command(16'sd0, 16'sd0, 16'd0);
      send_command(-16'sd32768, 16'sd0, 16'd0);
      wait_for_results();
      write_csr(icm_pkg::CSR_SUPPLY, 15'd1);
      send_command(16'sd0, 16'sd0, 16'd4000);
      send_command(16'sd1, 16'sd0, 16'd16384);
      wait_for_results();
      write_csr(icm_pkg::CSR_SUPPLY, 15'd32767);
      send_command(16'sd0, 16'sd0, 16'd0);
      send_command(16'sd32767, -16'sd32768, 16'd30000);
      wait_for_results();
   endtask

   task automatic test_random_traffic();
      send_idle_pct  = 23;
      recv_stall_pct = 65;
      write_csr(icm_pkg::CSR_SUPPLY, 15'($urandom));
      run_random(220);
      wait_for_results();

      send_idle_pct  = 65;
      recv_stall_pct = 23;
      write_csr(icm_pkg::CSR_CENTERED, 15'd0);
      write_csr(icm_pkg::CSR_SUPPLY, 15'($urandom));
      run_random(220);
      wait_for_results();

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_csr(icm_pkg::CSR_CENTERED, 15'd1);
      write_csr(icm_pkg::CSR_SUPPLY, 15'($urandom_range(6000)));
      run_random(220);
      wait_for_results();
   endtask

   // result side held off long enough that the pipeline fills and stalls the input
   task automatic test_output_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_csr(icm_pkg::CSR_SUPPLY, icm_pkg::SUPPLY_RST);
      hold_request <= hold_request + 1;
      run_random(40);
      wait_for_results();
   endtask

   initial begin
      send_idle_pct  = 23;
      recv_stall_pct = 65;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_centered_extremes();
      test_shifted_minimum();
      test_supply_limits();
      test_random_traffic();
      test_output_backpressure();
      $display("sent %0d voltage commands in centered and shifted modes, %0d phase sets checked",
               commands_sent, phase_sets_seen);
      $display("supply limit swept from 0 to 32767, input stalled by the block on %0d cycles",
               input_stalls);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("Mismatches found");
      $finish;
   end

endmodule

/* inverse_park_clarke_modulator.f */
+incdir+rtl
rtl/icm_pkg.sv
rtl/icm_sincos.sv
rtl/icm_rotate.sv
rtl/icm_phase.sv
rtl/inverse_park_clarke_modulator.sv
tb/tb_inverse_park_clarke_modulator.sv
